@@ design/scfla_pkg.sv @@
// Package for the size class free list allocator.
// Holds sizes, status codes, item types and ring address helpers.
// Used by the top level and scfla_search; depends on nothing.
package scfla_pkg;

   localparam int NUM_CLASSES     = 4;
   localparam int UNITS_PER_CLASS = 64;
   localparam int HEADER_BYTES    = 4;

   localparam int SIZE_W   = 16;
   localparam int UNIT_W   = 6;
   localparam int CLS_W    = 2;
   localparam int STATUS_W = 3;
   localparam int OFFSET_W = 22;

   localparam int PTR_W      = $clog2(UNITS_PER_CLASS);
   localparam int CNT_W      = $clog2(UNITS_PER_CLASS + 1);
   localparam int INUSE_W    = $clog2(NUM_CLASSES + 1);
   localparam int RING_DEPTH = NUM_CLASSES * UNITS_PER_CLASS;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int STRIDE_W   = SIZE_W + 1;
   localparam int PROD_W     = UNIT_W + STRIDE_W;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOSLOT   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EXHAUST  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd5;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [SIZE_W-1:0] block_bytes;
      logic [UNIT_W-1:0] unit_index;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic [STATUS_W-1:0] status;
      logic [CLS_W-1:0]    class_index;
      logic [UNIT_W-1:0]   granted_index;
      logic [OFFSET_W-1:0] byte_offset;
   } rsp_type;

   typedef struct packed {
      logic             done;
      logic             hit;
      logic [CLS_W-1:0] cls;
   } search_type;

   function automatic logic [RING_AW-1:0] ring_addr(input logic [CLS_W-1:0] cls,
                                                    input logic [PTR_W-1:0] ptr);
      int sum;
      sum = int'(cls) * UNITS_PER_CLASS + int'(ptr);
      return RING_AW'(sum);
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (32'(ptr) == UNITS_PER_CLASS - 1) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

endpackage

@@ design/size_class_free_list_allocator.sv @@
// Top level of the size class free list allocator: sequencer, class tables and ring RAM.
// Depends on scfla_pkg, scfla_ram and scfla_search.
//
// A request is taken when start is high and busy is low, and exactly one result item
// follows, shown for one cycle with rsp_strobe high; the receiver must take it then.
// A request with a zero size answers in the cycle after it is taken. Any other request walks the class
// table with one comparator, one class per cycle, stopping at the first match; a free or a failed
// allocate answers when the walk ends, and a successful allocate then reads the ring RAM and
// forms the byte offset with one multiply. No clearing pass follows reset: ring slots that were
// never written read as their own slot number.
module size_class_free_list_allocator import scfla_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int STATE_W = 2;
   localparam logic [STATE_W-1:0] S_IDLE   = 2'd0;
   localparam logic [STATE_W-1:0] S_SEARCH = 2'd1;
   localparam logic [STATE_W-1:0] S_READ   = 2'd2;
   localparam logic [STATE_W-1:0] S_OFFSET = 2'd3;

   logic [STATE_W-1:0] state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CLS_W-1:0]   cls_ff, cls_in;
   logic [PTR_W-1:0]   slot_ff, slot_in;
   logic               written_ff, written_in;
   logic [UNIT_W-1:0]  granted_ff, granted_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   rsp_type            rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;

   logic [SIZE_W-1:0]  size_ff [NUM_CLASSES];
   logic [SIZE_W-1:0]  size_in [NUM_CLASSES];
   logic [PTR_W-1:0]   head_ff [NUM_CLASSES];
   logic [PTR_W-1:0]   head_in [NUM_CLASSES];
   logic [PTR_W-1:0]   tail_ff [NUM_CLASSES];
   logic [PTR_W-1:0]   tail_in [NUM_CLASSES];
   logic [CNT_W-1:0]   count_ff [NUM_CLASSES];
   logic [CNT_W-1:0]   count_in [NUM_CLASSES];
   logic               wrap_ff [NUM_CLASSES];
   logic               wrap_in [NUM_CLASSES];
   logic [INUSE_W-1:0] in_use_ff, in_use_in;

   logic               search_go;
   search_type         search;

   logic               ram_wr_en;
   logic [RING_AW-1:0] ram_wr_addr;
   logic [UNIT_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [RING_AW-1:0] ram_rd_addr;
   logic [UNIT_W-1:0]  ram_rd_data;

   function automatic rsp_type make_rsp(input logic [STATUS_W-1:0] status,
                                        input logic [CLS_W-1:0] cls,
                                        input logic [UNIT_W-1:0] idx,
                                        input logic [OFFSET_W-1:0] off);
      rsp_type r;
      r.ok            = (status == ST_OK);
      r.status        = status;
      r.class_index   = cls;
      r.granted_index = idx;
      r.byte_offset   = off;
      return r;
   endfunction

   scfla_search u_search (
      .clock      (clock),
      .reset      (reset),
      .go         (search_go),
      .size_value (req_ff.block_bytes),
      .class_size (size_ff),
      .in_use     (in_use_ff),
      .result     (search)
   );

   scfla_ram #(
      .WIDTH (UNIT_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      logic [CLS_W-1:0]    c;
      logic [UNIT_W-1:0]   idx;
      logic [STRIDE_W-1:0] stride;
      logic [PROD_W-1:0]   off_sum;

      state_in   = state_ff;
      req_in     = req_ff;
      cls_in     = cls_ff;
      slot_in    = slot_ff;
      written_in = written_ff;
      granted_in = granted_ff;
      prod_in    = prod_ff;
      rsp_in     = rsp_ff;
      strobe_in  = 1'b0;
      size_in    = size_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      wrap_in    = wrap_ff;
      in_use_in  = in_use_ff;
      search_go  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      c       = search.cls;
      idx     = written_ff ? ram_rd_data : UNIT_W'(slot_ff);
      stride  = STRIDE_W'(req_ff.block_bytes) + STRIDE_W'(HEADER_BYTES);
      off_sum = prod_ff + PROD_W'(HEADER_BYTES);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_item;
               if (req_item.block_bytes == '0) begin
                  rsp_in    = make_rsp(ST_ZERO, '0, '0, '0);
                  strobe_in = 1'b1;
               end else begin
                  search_go = 1'b1;
                  state_in  = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (search.done) begin
               if (req_ff.mode == MODE_ALLOC) begin
                  if (!search.hit && (32'(in_use_ff) >= NUM_CLASSES)) begin
                     rsp_in    = make_rsp(ST_NOSLOT, '0, '0, '0);
                     strobe_in = 1'b1;
                     state_in  = S_IDLE;
                  end else begin
                     if (!search.hit) begin
                        c          = CLS_W'(in_use_ff);
                        size_in[c] = req_ff.block_bytes;
                        in_use_in  = in_use_ff + INUSE_W'(1);
                     end
                     cls_in = c;
                     if (count_ff[c] == '0) begin
                        rsp_in    = make_rsp(ST_EXHAUST, c, '0, '0);
                        strobe_in = 1'b1;
                        state_in  = S_IDLE;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ring_addr(c, head_ff[c]);
                        slot_in     = head_ff[c];
                        written_in  = wrap_ff[c] || (head_ff[c] < tail_ff[c]);
                        head_in[c]  = next_ptr(head_ff[c]);
                        count_in[c] = count_ff[c] - CNT_W'(1);
                        state_in    = S_READ;
                     end
                  end
               end else begin
                  if (!search.hit) begin
                     rsp_in = make_rsp(ST_UNKNOWN, '0, '0, '0);
                  end else if ((count_ff[c] >= CNT_W'(UNITS_PER_CLASS))
                               || (32'(req_ff.unit_index) >= UNITS_PER_CLASS)) begin
                     rsp_in = make_rsp(ST_OVERFLOW, c, '0, '0);
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = ring_addr(c, tail_ff[c]);
                     ram_wr_data = req_ff.unit_index;
                     tail_in[c]  = next_ptr(tail_ff[c]);
                     if (32'(tail_ff[c]) == UNITS_PER_CLASS - 1) begin
                        wrap_in[c] = 1'b1;
                     end
                     count_in[c] = count_ff[c] + CNT_W'(1);
                     rsp_in      = make_rsp(ST_OK, c, '0, '0);
                  end
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         S_READ: begin
            granted_in = idx;
            prod_in    = PROD_W'(idx) * PROD_W'(stride);
            state_in   = S_OFFSET;
         end
         S_OFFSET: begin
            rsp_in    = make_rsp(ST_OK, cls_ff, granted_ff, off_sum[OFFSET_W-1:0]);
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      cls_ff     <= cls_in;
      slot_ff    <= slot_in;
      written_ff <= written_in;
      granted_ff <= granted_in;
      prod_ff    <= prod_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
         in_use_ff <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            size_ff[i]  <= '0;
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= CNT_W'(UNITS_PER_CLASS);
            wrap_ff[i]  <= 1'b0;
         end
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         in_use_ff <= in_use_in;
         size_ff   <= size_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         wrap_ff   <= wrap_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("Result item shown while a request is still in progress.");

   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.ok == (rsp_item.status == ST_OK)))
      else $error("Result ok flag disagrees with its status.");

   a_zero_size: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.block_bytes == '0))
      |=> (rsp_strobe && (rsp_item.status == ST_ZERO) && !busy))
      else $error("Zero size request did not answer at once.");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.block_bytes != '0)) |=> (busy && !rsp_strobe))
      else $error("Nonzero request did not start a class search.");

endmodule

@@ design/scfla_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Used for the free index rings; depends on nothing.
module scfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/scfla_search.sv @@
// Class lookup unit: one size comparator stepped over the classes, matching only claimed ones.
// Depends on scfla_pkg.
module scfla_search import scfla_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [SIZE_W-1:0]  size_value,
   input  logic [SIZE_W-1:0]  class_size [NUM_CLASSES],
   input  logic [INUSE_W-1:0] in_use,
   output search_type         result
);

   logic             running_ff;
   logic             running_in;
   logic [CLS_W-1:0] scan_ff;
   logic [CLS_W-1:0] scan_in;
   logic             match;
   logic             last;

   assign match = running_ff && (32'(scan_ff) < 32'(in_use))
                  && (class_size[scan_ff] == size_value);
   assign last  = (32'(scan_ff) == NUM_CLASSES - 1);

   assign result.done = running_ff && (match || last);
   assign result.hit  = match;
   assign result.cls  = scan_ff;

   always_comb begin
      running_in = running_ff;
      scan_in    = scan_ff;
      if (go) begin
         running_in = 1'b1;
         scan_in    = '0;
      end else if (result.done) begin
         running_in = 1'b0;
      end else if (running_ff) begin
         scan_in = scan_ff + CLS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         scan_ff    <= '0;
      end else begin
         running_ff <= running_in;
         scan_ff    <= scan_in;
      end
   end

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for size_class_free_list_allocator: directed requests, then phases
// of random allocate and free traffic that drain and refill each size class in turn.
// Depends on scfla_pkg and the allocator RTL; a built-in predictor checks every reply.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import scfla_pkg::*;

   localparam int RANDOM_ITEMS = 1150;
   localparam int PHASE_ITEMS  = 150;
   localparam int STATUS_KINDS = 6;

   localparam logic [SIZE_W-1:0] SIZE_TINY = 16'h0001;
   localparam logic [SIZE_W-1:0] SIZE_HUGE = 16'hFFFF;
   localparam logic [SIZE_W-1:0] SIZE_ODD  = 16'h5555;
   localparam logic [SIZE_W-1:0] SIZE_EVEN = 16'hAAAA;
   localparam logic [SIZE_W-1:0] SIZE_LATE = 16'h1234;

   class pool_model;
      logic [SIZE_W-1:0] class_size [NUM_CLASSES];
      int                claimed;
      int                head [NUM_CLASSES];
      int                tail [NUM_CLASSES];
      int                free_units [NUM_CLASSES];
      logic [UNIT_W-1:0] ring [NUM_CLASSES][UNITS_PER_CLASS];
      logic [UNIT_W-1:0] held [NUM_CLASSES][$];
      rsp_type           pending_replies [$];
      int                failures;
      int                requests;
      int                status_seen [STATUS_KINDS];

      function new();
         claimed = 0;
         failures = 0;
         requests = 0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            class_size[c] = '0;
            head[c] = 0;
            tail[c] = 0;
            free_units[c] = UNITS_PER_CLASS;
            for (int i = 0; i < UNITS_PER_CLASS; i++) begin
               ring[c][i] = UNIT_W'(i);
            end
         end
         for (int s = 0; s < STATUS_KINDS; s++) begin
            status_seen[s] = 0;
         end
      endfunction

      function void take_request(req_type r);
         rsp_type           want;
         int                c;
         logic [UNIT_W-1:0] unit;
         want = '0;
         c = -1;
         requests++;
         for (int k = 0; k < claimed; k++) begin
            if (c < 0 && class_size[k] == r.block_bytes) begin
               c = k;
            end
         end
         if (r.block_bytes == '0) begin
            want.status = ST_ZERO;
         end else if (r.mode == MODE_ALLOC) begin
            if (c < 0 && claimed < NUM_CLASSES) begin
               c = claimed;
               class_size[c] = r.block_bytes;
               claimed++;
            end
            if (c < 0) begin
               want.status = ST_NOSLOT;
            end else begin
               want.class_index = CLS_W'(c);
               if (free_units[c] == 0) begin
                  want.status = ST_EXHAUST;
               end else begin
                  unit = ring[c][head[c]];
                  head[c] = (head[c] + 1) % UNITS_PER_CLASS;
                  free_units[c]--;
                  held[c].push_back(unit);
                  want.status = ST_OK;
                  want.granted_index = unit;
                  want.byte_offset = OFFSET_W'(int'(unit) * (int'(r.block_bytes) + HEADER_BYTES)
                                               + HEADER_BYTES);
               end
            end
         end else if (c < 0) begin
            want.status = ST_UNKNOWN;
         end else begin
            want.class_index = CLS_W'(c);
            if (free_units[c] >= UNITS_PER_CLASS || int'(r.unit_index) >= UNITS_PER_CLASS) begin
               want.status = ST_OVERFLOW;
            end else begin
               ring[c][tail[c]] = r.unit_index;
               tail[c] = (tail[c] + 1) % UNITS_PER_CLASS;
               free_units[c]++;
               want.status = ST_OK;
            end
         end
         want.ok = (want.status == ST_OK);
         pending_replies.push_back(want);
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (pending_replies.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("Reply with no request outstanding: ok=%0d status=%0d class=%0d",
                        got.ok, got.status, got.class_index);
               $display("   unit=%0d offset=%0h", got.granted_index, got.byte_offset);
            end
            return;
         end
         want = pending_replies.pop_front();
         if (int'(got.status) < STATUS_KINDS) begin
            status_seen[got.status]++;
         end
         if (got.ok !== want.ok || got.status !== want.status
             || got.class_index !== want.class_index
             || got.granted_index !== want.granted_index
             || got.byte_offset !== want.byte_offset) begin
            failures++;
            if (failures <= 10) begin
               $display("Mismatch at %0t: expected ok=%0d status=%0d class=%0d unit=%0d offset=%0h",
                        $realtime, want.ok, want.status, want.class_index, want.granted_index,
                        want.byte_offset);
               $display("                 actual ok=%0d status=%0d class=%0d unit=%0d offset=%0h",
                        got.ok, got.status, got.class_index, got.granted_index, got.byte_offset);
            end
         end
      endfunction
   endclass

   logic      clock;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   req_type   req_item = '0;
   logic      rsp_strobe;
   rsp_type   rsp_item;
   pool_model pool;

   size_class_free_list_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         pool.check_reply(rsp_item);
      end
   end

   function automatic req_type make_req(logic m, logic [SIZE_W-1:0] s, logic [UNIT_W-1:0] i);
      req_type r;
      r.mode = m;
      r.block_bytes = s;
      r.unit_index = i;
      return r;
   endfunction

   task automatic send_request(input req_type r);
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      pool.take_request(r);
   endtask

   task automatic idle_for(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_replies();
      start <= 1'b0;
      while (pool.pending_replies.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      req_type r;
      int      phase;
      int      focus;
      int      bias;
      int      roll;
      int      c;
      int      k;
      bit      quiet;

      pool = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(make_req(MODE_ALLOC, '0, '0));
      send_request(make_req(MODE_FREE, '0, 6'd63));
      send_request(make_req(MODE_FREE, SIZE_TINY, 6'd0));
      send_request(make_req(MODE_ALLOC, SIZE_TINY, 6'd0));
      send_request(make_req(MODE_ALLOC, SIZE_TINY, 6'd63));
      send_request(make_req(MODE_FREE, SIZE_TINY, 6'd63));
      idle_for(3);
      send_request(make_req(MODE_FREE, SIZE_TINY, 6'd0));
      send_request(make_req(MODE_FREE, SIZE_TINY, 6'd1));
      send_request(make_req(MODE_ALLOC, SIZE_HUGE, 6'd21));
      send_request(make_req(MODE_ALLOC, SIZE_HUGE, 6'd42));
      send_request(make_req(MODE_ALLOC, SIZE_ODD, 6'd0));
      idle_for(1);
      send_request(make_req(MODE_ALLOC, SIZE_EVEN, 6'd0));
      send_request(make_req(MODE_ALLOC, SIZE_LATE, 6'd0));
      send_request(make_req(MODE_FREE, SIZE_LATE, 6'd5));
      send_request(make_req(MODE_ALLOC, SIZE_TINY, 6'd63));
      send_request(make_req(MODE_FREE, SIZE_HUGE, 6'd1));
      send_request(make_req(MODE_FREE, SIZE_ODD, 6'd0));
      send_request(make_req(MODE_FREE, SIZE_EVEN, 6'd0));
      send_request(make_req(MODE_FREE, SIZE_EVEN, 6'd0));
      pool.held[1].delete();
      pool.held[2].delete();
      pool.held[3].delete();

      // Each pair of phases drains one class to exhaustion and then refills it past full.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            drain_replies();
         end
         phase = n / PHASE_ITEMS;
         focus = (phase / 2) % NUM_CLASSES;
         bias = (phase % 2 == 0) ? 85 : 15;
         quiet = (phase == 2) || (n >= RANDOM_ITEMS - PHASE_ITEMS);
         roll = $urandom_range(0, 99);
         r.mode = ($urandom_range(0, 99) < bias) ? MODE_ALLOC : MODE_FREE;
         r.unit_index = UNIT_W'($urandom);
         if (roll < 3) begin
            r.block_bytes = '0;
         end else if (roll < 8) begin
            r.block_bytes = SIZE_W'($urandom);
         end else begin
            c = ($urandom_range(0, 99) < 70) ? focus : $urandom_range(0, NUM_CLASSES - 1);
            r.block_bytes = pool.class_size[c];
            if (r.mode == MODE_FREE && pool.held[c].size() != 0
                && $urandom_range(0, 19) != 0) begin
               k = $urandom_range(0, pool.held[c].size() - 1);
               r.unit_index = pool.held[c][k];
               pool.held[c].delete(k);
            end
         end
         send_request(r);
         if (!quiet && $urandom_range(0, 3) == 0) begin
            idle_for($urandom_range(1, 11));
         end
      end

      drain_replies();
      repeat (10) @(posedge clock);
      if (pool.pending_replies.size() != 0) begin
         pool.failures++;
         $display("%0d replies never arrived", pool.pending_replies.size());
      end
      $display("Sent %0d requests over four size classes: %0d succeeded, %0d zero size,",
               pool.requests, pool.status_seen[ST_OK], pool.status_seen[ST_ZERO]);
      $display("%0d without a class slot, %0d exhausted, %0d unknown size, %0d overflowing frees",
               pool.status_seen[ST_NOSLOT], pool.status_seen[ST_EXHAUST],
               pool.status_seen[ST_UNKNOWN], pool.status_seen[ST_OVERFLOW]);
      if (pool.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d failures", pool.failures);
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out waiting for the allocator");
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ size_class_free_list_allocator.f @@
design/scfla_pkg.sv
design/scfla_ram.sv
design/scfla_search.sv
design/size_class_free_list_allocator.sv
bench/testbench.sv
